>>> rtl/kmcets_pkg.sv
package kmcets_pkg;

	localparam int unsigned NUM_PROCS = 16;
	localparam int unsigned NUM_SITES = 256;
	localparam int unsigned MEM_AW    = 12;

	localparam logic [2:0] OP_ADD      = 3'd0;
	localparam logic [2:0] OP_DELETE   = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_SET_RATE = 3'd3;
	localparam logic [2:0] OP_REFRESH  = 3'd4;
	localparam logic [2:0] OP_SELECT   = 3'd5;
	localparam logic [2:0] OP_QUERY    = 3'd6;
	localparam logic [2:0] OP_READ     = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_ENROL   = 2'd2;
	localparam logic [1:0] ST_NO_DATA = 2'd3;

	localparam logic REG_PROCS = 1'b0;
	localparam logic REG_SITES = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  process_id;
		logic [7:0]  site_id;
		logic [7:0]  slot_position;
		logic [23:0] rate_value;
		logic [39:0] draw_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  chosen_process;
		logic [7:0]  chosen_site;
		logic        is_member;
		logic [8:0]  member_count;
		logic [23:0] rate_read;
		logic [39:0] total_read;
	} out_item_t;

endpackage

>>> rtl/kmc_event_table_select.sv
// Event table for kinetic Monte Carlo event selection.
// Input channel in_valid/in_ready carries one operation item; output channel
// out_valid/out_ready returns exactly one result item for each.
// Items are worked one at a time by a sequencer around two simple dual-port
// synchronous memories (site list and site-to-slot map, 4096 entries each).
// Work per item, accept to result valid:
//   add, query, read_slot: memory reads; delete: also a move step when the
//   last entry moves; clear, set_rate, argument out of range: the check only;
//   duplicate add, delete of a site not enrolled: memory reads;
//   refresh: a multiply-accumulate for each of the 16 processes;
//   select: the binary search (up to 4 probes and a closing step), the skip
//   over empty processes (up to 15) and the 40-step restoring divider; the
//   divider is bypassed when the rate is zero, and no data ends it early.
// After reset all 4096 entries of the slot map are swept to "not enrolled",
// and in_ready stays low meanwhile; APB writes are taken throughout.
// A finished result waits in the output register while the receiver
// stalls; the next item is then accepted and worked, and its result is held
// until the output register frees. Configuration (procs_in_use at 0x0,
// sites_in_use at 0x4) is to be written by the user only while idle; the block does not enforce this.
module kmc_event_table_select (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  kmcets_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output kmcets_pkg::out_item_t out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CHK, S_SI, S_SL, S_DEL, S_RMUL, S_RADD,
		S_SRCH, S_SKIP, S_PREV, S_DIV, S_KSEL, S_PICK, S_SLOUT, S_OUT
	} state_t;

	state_t state_q;
	kmcets_pkg::in_item_t  in_q;
	kmcets_pkg::out_item_t res_q;

	logic [4:0] procs_q;
	logic [8:0] sites_q;
	logic [4:0] np;
	logic [8:0] ns;
	logic       p_ok, s_ok;

	logic [8:0]  cnt_q  [kmcets_pkg::NUM_PROCS];
	logic [23:0] rate_q [kmcets_pkg::NUM_PROCS];
	logic [39:0] tot_q  [kmcets_pkg::NUM_PROCS];
	logic [3:0]  rd_idx;
	logic [8:0]  cnt_rd;
	logic [23:0] rate_rd;
	logic [39:0] tot_rd;

	logic [7:0] sl_mem [2**kmcets_pkg::MEM_AW];
	logic [8:0] si_mem [2**kmcets_pkg::MEM_AW];
	logic       sl_we, si_we;
	logic [kmcets_pkg::MEM_AW-1:0] sl_wa, sl_ra, si_wa, si_ra;
	logic [7:0] sl_wd, sl_rd;
	logic [8:0] si_wd, si_rd;

	logic [kmcets_pkg::MEM_AW:0] init_q;
	logic [8:0]  slot_q;
	logic        memb;
	logic [8:0]  last;
	logic [3:0]  i_q, lo_q, hi_q, mid;
	logic [4:0]  q_q;
	logic [39:0] draw_q, sum_q, dvd_q, prev;
	logic [32:0] prod_s2;
	logic [40:0] sum_n;
	logic [39:0] sum_sat;
	logic [23:0] r_q, rem_q;
	logic [8:0]  n_q, nm1;
	logic [24:0] rem_n, rem_sub;
	logic        rem_ge;
	logic [5:0]  step_q;
	logic [7:0]  k_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kmcets_pkg::REG_SITES) ? {23'd0, sites_q}
		: {27'd0, procs_q};

	assign np = (procs_q == 5'd0) ? 5'd1 : ((procs_q > 5'd16) ? 5'd16 : procs_q);
	assign ns = (sites_q == 9'd0) ? 9'd1 : ((sites_q > 9'd256) ? 9'd256 : sites_q);
	assign p_ok = {1'b0, in_q.process_id} < np;
	assign s_ok = {1'b0, in_q.site_id} < ns;
	assign in_ready = (state_q == S_IDLE);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		case (state_q)
			S_CHK:   rd_idx = (in_q.operation == kmcets_pkg::OP_SELECT) ?
				4'(np - 5'd1) : in_q.process_id;
			S_SRCH:  rd_idx = mid;
			S_SKIP:  rd_idx = q_q[3:0];
			S_PREV:  rd_idx = q_q[3:0] - 4'd1;
			S_RMUL:  rd_idx = i_q;
			default: rd_idx = in_q.process_id;
		endcase
	end

	assign cnt_rd  = cnt_q[rd_idx];
	assign rate_rd = rate_q[rd_idx];
	assign tot_rd  = tot_q[rd_idx];

	assign memb = (slot_q < cnt_rd) && (sl_rd == in_q.site_id);
	assign last = cnt_rd - 9'd1;
	assign sum_n = {1'b0, sum_q} + {8'd0, prod_s2};
	assign sum_sat = sum_n[40] ? '1 : sum_n[39:0];
	assign prev = (q_q == 5'd0) ? 40'd0 : tot_rd;
	assign rem_n = {1'b0, rem_q[22:0], dvd_q[39]} | {rem_q[23], 24'd0};
	assign rem_ge = rem_n >= {1'b0, r_q};
	assign rem_sub = rem_n - {1'b0, r_q};
	assign nm1 = n_q - 9'd1;

	// memory ports
	always_comb begin
		sl_we = 1'b0;
		sl_wa = {in_q.process_id, cnt_rd[7:0]};
		sl_wd = in_q.site_id;
		si_we = 1'b0;
		si_wa = {in_q.process_id, in_q.site_id};
		si_wd = cnt_rd;
		sl_ra = {in_q.process_id, si_rd[7:0]};
		si_ra = {in_q.process_id, in_q.site_id};
		case (state_q)
			S_INIT: begin
				si_we = 1'b1;
				si_wa = init_q[kmcets_pkg::MEM_AW-1:0];
				si_wd = 9'h100;
			end
			S_SL: begin
				sl_ra = {in_q.process_id, last[7:0]};
				if (in_q.operation == kmcets_pkg::OP_ADD && !memb
					&& cnt_rd < 9'd256) begin
					sl_we = 1'b1;
					si_we = 1'b1;
				end
			end
			S_DEL: begin
				sl_we = 1'b1;
				sl_wa = {in_q.process_id, slot_q[7:0]};
				sl_wd = sl_rd;
				si_we = 1'b1;
				si_wa = {in_q.process_id, sl_rd};
				si_wd = slot_q;
			end
			S_PICK: sl_ra = {q_q[3:0], k_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we)
			sl_mem[sl_wa] <= sl_wd;
		sl_rd <= sl_mem[sl_ra];
	end

	always_ff @(posedge clk) begin
		if (si_we)
			si_mem[si_wa] <= si_wd;
		si_rd <= si_mem[si_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			procs_q <= 5'd16;
			sites_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == kmcets_pkg::REG_SITES)
				sites_q <= pwdata[8:0];
			else
				procs_q <= pwdata[4:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 33'(rate_rd) * 33'(cnt_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			out_valid <= 1'b0;
			out_item  <= '0;
			in_q      <= '0;
			res_q     <= '0;
			init_q    <= '0;
			for (int j = 0; j < kmcets_pkg::NUM_PROCS; j++) begin
				cnt_q[j]  <= '0;
				rate_q[j] <= '0;
				tot_q[j]  <= '0;
			end
		end else begin
			if (out_valid && out_ready && state_q != S_OUT)
				out_valid <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (kmcets_pkg::MEM_AW+1)'(2**kmcets_pkg::MEM_AW - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_item;
						res_q   <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= S_OUT;
					case (in_q.operation) inside
						kmcets_pkg::OP_ADD, kmcets_pkg::OP_DELETE,
						kmcets_pkg::OP_QUERY: begin
							if (!p_ok || !s_ok)
								res_q.status <= kmcets_pkg::ST_RANGE;
							else
								state_q <= S_SI;
						end
						kmcets_pkg::OP_CLEAR: begin
							for (int j = 0; j < kmcets_pkg::NUM_PROCS; j++) begin
								cnt_q[j] <= '0;
								tot_q[j] <= '0;
							end
						end
						kmcets_pkg::OP_SET_RATE: begin
							if (!p_ok)
								res_q.status <= kmcets_pkg::ST_RANGE;
							else
								rate_q[in_q.process_id] <= in_q.rate_value;
						end
						kmcets_pkg::OP_REFRESH: begin
							i_q     <= '0;
							sum_q   <= '0;
							state_q <= S_RMUL;
						end
						kmcets_pkg::OP_SELECT: begin
							if (tot_rd == 40'd0) begin
								res_q.status <= kmcets_pkg::ST_NO_DATA;
							end else begin
								draw_q  <= (in_q.draw_value >= tot_rd) ?
									tot_rd - 40'd1 : in_q.draw_value;
								lo_q    <= '0;
								hi_q    <= 4'(np - 5'd1);
								state_q <= S_SRCH;
							end
						end
						default: begin
							if (!p_ok || {1'b0, in_q.slot_position} >= cnt_rd) begin
								res_q.status <= kmcets_pkg::ST_RANGE;
							end else begin
								q_q     <= {1'b0, in_q.process_id};
								k_q     <= in_q.slot_position;
								state_q <= S_PICK;
							end
						end
					endcase
				end
				S_SI: begin
					slot_q  <= si_rd;
					state_q <= S_SL;
				end
				S_SL: begin
					state_q <= S_OUT;
					case (in_q.operation)
						kmcets_pkg::OP_ADD: begin
							if (memb || cnt_rd >= 9'd256)
								res_q.status <= kmcets_pkg::ST_ENROL;
							else
								cnt_q[in_q.process_id] <= cnt_rd + 9'd1;
						end
						kmcets_pkg::OP_DELETE: begin
							if (!memb || cnt_rd == 9'd0)
								res_q.status <= kmcets_pkg::ST_ENROL;
							else if (slot_q != last)
								state_q <= S_DEL;
							else
								cnt_q[in_q.process_id] <= last;
						end
						default: begin
							res_q.is_member    <= memb;
							res_q.member_count <= cnt_rd;
							res_q.rate_read    <= rate_rd;
							res_q.total_read   <= tot_rd;
						end
					endcase
				end
				S_DEL: begin
					cnt_q[in_q.process_id] <= last;
					state_q <= S_OUT;
				end
				S_RMUL: state_q <= S_RADD;
				S_RADD: begin
					if ({1'b0, i_q} < np) begin
						tot_q[i_q] <= sum_sat;
						sum_q      <= sum_sat;
					end else begin
						tot_q[i_q] <= '0;
					end
					i_q     <= i_q + 4'd1;
					state_q <= (i_q == 4'd15) ? S_OUT : S_RMUL;
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						if (tot_rd > draw_q)
							hi_q <= mid;
						else
							lo_q <= mid + 4'd1;
					end else begin
						q_q     <= {1'b0, lo_q};
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (q_q >= np) begin
						res_q.status <= kmcets_pkg::ST_NO_DATA;
						state_q      <= S_OUT;
					end else if (cnt_rd == 9'd0) begin
						q_q <= q_q + 5'd1;
					end else begin
						r_q <= rate_rd;
						n_q <= cnt_rd;
						res_q.chosen_process <= q_q[3:0];
						state_q <= S_PREV;
					end
				end
				S_PREV: begin
					if (r_q != 24'd0 && draw_q >= prev) begin
						dvd_q   <= draw_q - prev;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						k_q     <= '0;
						state_q <= S_PICK;
					end
				end
				S_DIV: begin
					rem_q  <= rem_ge ? rem_sub[23:0] : rem_n[23:0];
					dvd_q  <= {dvd_q[38:0], rem_ge};
					step_q <= step_q + 6'd1;
					if (step_q == 6'd39)
						state_q <= S_KSEL;
				end
				S_KSEL: begin
					k_q     <= (dvd_q >= {31'd0, n_q}) ? nm1[7:0] : dvd_q[7:0];
					state_q <= S_PICK;
				end
				S_PICK: state_q <= S_SLOUT;
				S_SLOUT: begin
					res_q.chosen_site <= sl_rd;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_item  <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != kmcets_pkg::ST_OK |->
			out_item.chosen_process == 4'd0 && out_item.chosen_site == 8'd0
			&& out_item.member_count == 9'd0 && out_item.total_read == 40'd0)
		else $error("error result carries data");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is at work");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_rd <= 9'd256)
		else $error("process count above site capacity");

	a_sel_proc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SLOUT && in_q.operation == kmcets_pkg::OP_SELECT |->
			{1'b0, res_q.chosen_process} < np)
		else $error("selected process not in use");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid && !out_ready |=> state_q == S_OUT)
		else $error("result dropped while receiver stalls");

endmodule

>>> tb/sv/kmc_event_table_select_checker.sv
module kmc_event_table_select_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  kmcets_pkg::in_item_t  in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  kmcets_pkg::out_item_t out_item,
	input  logic                  cfg_we,
	input  logic                  cfg_sel,
	input  logic [8:0]            cfg_val,
	output int                    fail_count,
	output int                    pending
);

	logic [7:0]  list_site [kmcets_pkg::NUM_PROCS][kmcets_pkg::NUM_SITES];
	logic [7:0]  slot_of [kmcets_pkg::NUM_PROCS][kmcets_pkg::NUM_SITES];
	bit          enrolled [kmcets_pkg::NUM_PROCS][kmcets_pkg::NUM_SITES];
	logic [8:0]  count [kmcets_pkg::NUM_PROCS];
	logic [23:0] rate [kmcets_pkg::NUM_PROCS];
	logic [39:0] total [kmcets_pkg::NUM_PROCS];
	logic [4:0]  procs_reg;
	logic [8:0]  sites_reg;
	kmcets_pkg::out_item_t expected_q [$];

	assign pending = expected_q.size();

	function automatic int eff_procs();
		if (procs_reg == 0) return 1;
		return procs_reg > kmcets_pkg::NUM_PROCS ? kmcets_pkg::NUM_PROCS : int'(procs_reg);
	endfunction

	function automatic int eff_sites();
		if (sites_reg == 0) return 1;
		return sites_reg > kmcets_pkg::NUM_SITES ? kmcets_pkg::NUM_SITES : int'(sites_reg);
	endfunction

	task automatic apply_op(input kmcets_pkg::in_item_t it,
		output kmcets_pkg::out_item_t r);
		int np, ns, p, s, k, last, mv, lo, hi, mid, q, n;
		bit p_ok, s_ok;
		logic [63:0] sum, d, draw, prev, tot;
		np = eff_procs();
		ns = eff_sites();
		p = int'(it.process_id);
		s = int'(it.site_id);
		p_ok = p < np;
		s_ok = s < ns;
		r = '0;
		case (it.operation)
			kmcets_pkg::OP_ADD: begin
				if (!p_ok || !s_ok) r.status = kmcets_pkg::ST_RANGE;
				else if (enrolled[p][s] || count[p] >= kmcets_pkg::NUM_SITES)
					r.status = kmcets_pkg::ST_ENROL;
				else begin
					k = int'(count[p]);
					list_site[p][k] = 8'(s);
					slot_of[p][s] = 8'(k);
					enrolled[p][s] = 1'b1;
					count[p] = 9'(k + 1);
				end
			end
			kmcets_pkg::OP_DELETE: begin
				if (!p_ok || !s_ok) r.status = kmcets_pkg::ST_RANGE;
				else if (!enrolled[p][s] || count[p] == 0) r.status = kmcets_pkg::ST_ENROL;
				else begin
					k = int'(slot_of[p][s]);
					last = int'(count[p]) - 1;
					if (k != last) begin
						mv = int'(list_site[p][last]);
						list_site[p][k] = 8'(mv);
						slot_of[p][mv] = 8'(k);
					end
					enrolled[p][s] = 1'b0;
					count[p] = 9'(last);
				end
			end
			kmcets_pkg::OP_CLEAR: begin
				for (int i = 0; i < kmcets_pkg::NUM_PROCS; i++) begin
					count[i] = '0;
					total[i] = '0;
					for (int j = 0; j < kmcets_pkg::NUM_SITES; j++) enrolled[i][j] = 1'b0;
				end
			end
			kmcets_pkg::OP_SET_RATE: begin
				if (!p_ok) r.status = kmcets_pkg::ST_RANGE;
				else rate[p] = it.rate_value;
			end
			kmcets_pkg::OP_REFRESH: begin
				sum = '0;
				for (int i = 0; i < kmcets_pkg::NUM_PROCS; i++) begin
					if (i < np) begin
						sum += 64'(rate[i]) * 64'(count[i]);
						if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
						total[i] = sum[39:0];
					end else total[i] = '0;
				end
			end
			kmcets_pkg::OP_SELECT: begin
				tot = 64'(total[np-1]);
				draw = 64'(it.draw_value);
				if (tot == 0) r.status = kmcets_pkg::ST_NO_DATA;
				else begin
					if (draw >= tot) draw = tot - 64'd1;
					lo = 0;
					hi = np - 1;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (64'(total[mid]) > draw) hi = mid;
						else lo = mid + 1;
					end
					q = lo;
					while (q < np && count[q] == 0) q++;
					if (q >= np) r.status = kmcets_pkg::ST_NO_DATA;
					else begin
						prev = (q == 0) ? 64'd0 : 64'(total[q-1]);
						n = int'(count[q]);
						k = 0;
						if (rate[q] != 0 && draw >= prev) begin
							d = (draw - prev) / 64'(rate[q]);
							k = d >= 64'(n) ? n - 1 : int'(d);
						end
						r.chosen_process = 4'(q);
						r.chosen_site = list_site[q][k];
					end
				end
			end
			kmcets_pkg::OP_QUERY: begin
				if (!p_ok || !s_ok) r.status = kmcets_pkg::ST_RANGE;
				else begin
					r.is_member = enrolled[p][s];
					r.member_count = count[p];
					r.rate_read = rate[p];
					r.total_read = total[p];
				end
			end
			default: begin
				if (!p_ok || {1'b0, it.slot_position} >= count[p])
					r.status = kmcets_pkg::ST_RANGE;
				else r.chosen_site = list_site[p][it.slot_position];
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		kmcets_pkg::out_item_t r, e;
		if (!arst_n) begin
			for (int i = 0; i < kmcets_pkg::NUM_PROCS; i++) begin
				count[i] = '0;
				rate[i] = '0;
				total[i] = '0;
				for (int j = 0; j < kmcets_pkg::NUM_SITES; j++) enrolled[i][j] = 1'b0;
			end
			procs_reg = 5'd16;
			sites_reg = 9'd256;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %h", out_item);
				end else begin
					e = expected_q.pop_front();
					if (out_item !== e) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp st=%0d cp=%0d cs=%0d m=%0d c=%0d r=%0d t=%0d",
								e.status, e.chosen_process, e.chosen_site, e.is_member,
								e.member_count, e.rate_read, e.total_read);
							$display("          got st=%0d cp=%0d cs=%0d m=%0d c=%0d r=%0d t=%0d",
								out_item.status, out_item.chosen_process,
								out_item.chosen_site, out_item.is_member,
								out_item.member_count, out_item.rate_read,
								out_item.total_read);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				apply_op(in_item, r);
				expected_q.push_back(r);
			end
			if (cfg_we) begin
				if (cfg_sel == kmcets_pkg::REG_PROCS) procs_reg = cfg_val[4:0];
				else sites_reg = cfg_val;
			end
		end
	end

endmodule

>>> tb/sv/kmc_event_table_select_tb.sv
module kmc_event_table_select_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	kmcets_pkg::in_item_t  in_item = '0;
	logic        out_valid;
	logic        out_ready = 0;
	kmcets_pkg::out_item_t out_item;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending;
	int          cycle_count = 0;
	bit          hold_off = 0;
	bit          sink_on = 0;
	int          sel_procs = 16, sel_sites = 256;

	always #10 clk = ~clk;

	kmc_event_table_select uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	kmc_event_table_select_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(psel && penable && pwrite && pready),
		.cfg_sel(paddr[2]), .cfg_val(pwdata[8:0]),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 900000) begin
			$display("kmc_event_table_select_tb failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end else if (sink_on) begin
				g = gap_len();
				if (g == 0) out_ready <= 1;
				else begin
					out_ready <= 0;
					repeat (g - 1) @(posedge clk);
				end
			end else out_ready <= 1;
		end
	end

	// valid stays high into the next item when there is no gap
	task automatic send(input kmcets_pkg::in_item_t it, input bit gaps);
		int g;
		if (gaps) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 0;
				repeat (g) @(posedge clk);
			end
		end
		in_valid <= 1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr_bit, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {addr_bit, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	function automatic kmcets_pkg::in_item_t mk(input logic [2:0] op, input int p,
		input int s);
		kmcets_pkg::in_item_t it;
		it.operation = op;
		it.process_id = 4'(p);
		it.site_id = 8'(s);
		it.slot_position = 8'($urandom);
		it.rate_value = 24'($urandom);
		it.draw_value = 40'({$urandom, $urandom});
		return it;
	endfunction

	function automatic kmcets_pkg::in_item_t rand_item();
		kmcets_pkg::in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it = mk(kmcets_pkg::OP_ADD, $urandom_range(0, sel_procs),
			$urandom_range(0, sel_sites));
		if (r < 30) it.operation = kmcets_pkg::OP_ADD;
		else if (r < 42) it.operation = kmcets_pkg::OP_DELETE;
		else if (r < 44) it.operation = kmcets_pkg::OP_CLEAR;
		else if (r < 52) it.operation = kmcets_pkg::OP_SET_RATE;
		else if (r < 60) it.operation = kmcets_pkg::OP_REFRESH;
		else if (r < 80) it.operation = kmcets_pkg::OP_SELECT;
		else if (r < 90) it.operation = kmcets_pkg::OP_QUERY;
		else begin
			it.operation = kmcets_pkg::OP_READ;
			it.slot_position = 8'($urandom_range(0, 12));
		end
		if ($urandom_range(0, 9) == 0) begin
			it.process_id = 4'($urandom);
			it.site_id = 8'($urandom);
		end
		case ($urandom_range(0, 3))
			0: it.rate_value = 24'($urandom_range(0, 15));
			1: it.rate_value = 24'($urandom_range(0, 4095));
			default: ;
		endcase
		if ($urandom_range(0, 1) != 0) it.draw_value = 40'($urandom_range(0, 1 << 20));
		return it;
	endfunction

	initial begin
		kmcets_pkg::in_item_t it;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed
		sink_on = 0;
		send(mk(kmcets_pkg::OP_SELECT, 0, 0), 0);
		send(mk(kmcets_pkg::OP_READ, 0, 0), 0);
		send(mk(kmcets_pkg::OP_ADD, 0, 0), 0);
		send(mk(kmcets_pkg::OP_ADD, 0, 255), 0);
		send(mk(kmcets_pkg::OP_ADD, 15, 7), 0);
		send(mk(kmcets_pkg::OP_ADD, 15, 8), 0);
		send(mk(kmcets_pkg::OP_ADD, 0, 0), 0);
		send(mk(kmcets_pkg::OP_DELETE, 0, 9), 0);
		it = mk(kmcets_pkg::OP_SET_RATE, 0, 0); it.rate_value = 24'hFFFFFF; send(it, 0);
		it = mk(kmcets_pkg::OP_SET_RATE, 15, 0); it.rate_value = '0; send(it, 0);
		send(mk(kmcets_pkg::OP_SELECT, 0, 0), 0);
		send(mk(kmcets_pkg::OP_REFRESH, 0, 0), 0);
		it = mk(kmcets_pkg::OP_SELECT, 0, 0); it.draw_value = '0; send(it, 0);
		it = mk(kmcets_pkg::OP_SELECT, 0, 0); it.draw_value = 40'hFF_FFFF_FFFF;
		send(it, 0);
		send(mk(kmcets_pkg::OP_QUERY, 15, 7), 0);
		send(mk(kmcets_pkg::OP_QUERY, 0, 255), 0);
		it = mk(kmcets_pkg::OP_READ, 0, 0); it.slot_position = 8'd1; send(it, 0);
		it = mk(kmcets_pkg::OP_READ, 0, 0); it.slot_position = 8'd255; send(it, 0);
		send(mk(kmcets_pkg::OP_DELETE, 0, 0), 0);
		send(mk(kmcets_pkg::OP_DELETE, 15, 7), 0);
		send(mk(kmcets_pkg::OP_SELECT, 0, 0), 0);
		send(mk(kmcets_pkg::OP_CLEAR, 0, 0), 0);
		send(mk(kmcets_pkg::OP_QUERY, 0, 255), 0);
		drain();

		sink_on = 1;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin sel_procs = 16; sel_sites = 20; end
				1: begin write_reg(kmcets_pkg::REG_PROCS, 1);
					write_reg(kmcets_pkg::REG_SITES, 1);
					sel_procs = 2; sel_sites = 3; end
				2: begin write_reg(kmcets_pkg::REG_PROCS, 4);
					write_reg(kmcets_pkg::REG_SITES, 12);
					sel_procs = 5; sel_sites = 14; end
				3: begin write_reg(kmcets_pkg::REG_PROCS, 0);
					write_reg(kmcets_pkg::REG_SITES, 0);
					sel_procs = 2; sel_sites = 2; end
				default: begin write_reg(kmcets_pkg::REG_PROCS, 31);
					write_reg(kmcets_pkg::REG_SITES, 511);
					sel_procs = 15; sel_sites = 255; end
			endcase
			for (int n = 0; n < 90; n++) begin
				if (ph == 2 && n == 10) hold_off = 1;
				send(rand_item(), 1);
			end
			drain();
		end

		if (fail_count == 0) $display("kmc_event_table_select_tb passed");
		else $display("kmc_event_table_select_tb failed");
		$finish;
	end

endmodule
